// ----- rtl/stt_pkg.sv -----
// Shared types, codes and constants of the software timer table.
package stt_pkg;

   localparam int DEFAULT_TIMER_SLOTS = 16;
   localparam int MAX_RESULTS         = 16;
   localparam int ID_W                = 32;
   localparam int SPAN_W              = 32;
   localparam int TIME_W              = 48;

   localparam logic [1:0] OP_CREATE  = 2'd0;
   localparam logic [1:0] OP_DESTROY = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic [1:0] KIND_CREATED = 2'd0;
   localparam logic [1:0] KIND_FIRED   = 2'd1;
   localparam logic [1:0] KIND_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [SPAN_W-1:0] span_ticks;
      logic              one_shot;
      logic [ID_W-1:0]   target_id;
   } stt_req_type;

   typedef struct packed {
      logic [1:0]      kind;
      logic [ID_W-1:0] timer_id;
      logic            last_of_run;
   } stt_rsp_type;

   // one table entry as stored in the slot memory
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SPAN_W-1:0] span;
      logic [TIME_W-1:0] last_fired;
      logic              one_shot;
   } stt_slot_type;

endpackage

// ----- rtl/stt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/software_timer_table_core.sv -----
// One item at a time; the walk over the slot memory, one slot per cycle, sets the rate.
// Result stalls pause the walk; a tick buffers one fired word to mark the last of its run.
// Reset (synchronous) clears all slot valid bits, the id counter and the time counter.
// Slot memory contents are not cleared; entries are only read behind a set valid bit.
module software_timer_table_core #(
   parameter int TIMER_SLOTS = stt_pkg::DEFAULT_TIMER_SLOTS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  stt_pkg::stt_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output stt_pkg::stt_rsp_type rsp_data
);

   localparam int IDX_W  = $clog2(TIMER_SLOTS);
   localparam int CNT_W  = $clog2(stt_pkg::MAX_RESULTS + 1);
   localparam int SLOT_W = $bits(stt_pkg::stt_slot_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_CREATE, ST_WALK, ST_FLUSH} state_type;

   state_type                        state_ff, state_in;
   stt_pkg::stt_req_type             item_ff, item_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic                             more_ff, more_in;
   logic                             ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]                 ev_idx_ff, ev_idx_in;
   logic [TIMER_SLOTS-1:0]           valid_ff, valid_in;
   logic [stt_pkg::ID_W-1:0]         id_ctr_ff, id_ctr_in;
   logic [stt_pkg::TIME_W-1:0]       time_ff, time_in;
   logic                             pend_vld_ff, pend_vld_in;
   logic [stt_pkg::ID_W-1:0]         pend_id_ff, pend_id_in;
   logic [CNT_W-1:0]                 rpt_cnt_ff, rpt_cnt_in;
   logic                             rsp_vld_ff, rsp_vld_in;
   stt_pkg::stt_rsp_type             rsp_ff, rsp_in;

   logic                             ram_we, ram_re;
   logic [IDX_W-1:0]                 ram_waddr, ram_raddr;
   stt_pkg::stt_slot_type            ram_wdata, ram_rdata;

   logic                             acc, rsp_free, ev_live, hit, fire, report, go;
   logic                             is_tick;
   logic [stt_pkg::TIME_W:0]         due;

   stt_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(TIMER_SLOTS)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign acc       = req_valid && !req_stall;
   assign rsp_free  = !rsp_vld_ff || !rsp_stall;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // slot under evaluation; its data comes from the registered read that took it up
   assign is_tick = (item_ff.opcode == stt_pkg::OP_TICK);
   assign ev_live = ev_vld_ff && valid_ff[ev_idx_ff];
   assign hit     = ev_live && (ram_rdata.id == item_ff.target_id);
   assign due     = {1'b0, ram_rdata.last_fired}
                  + {{(stt_pkg::TIME_W + 1 - stt_pkg::SPAN_W){1'b0}}, ram_rdata.span};
   assign fire    = ev_live && (due < {1'b0, time_ff});
   assign report  = fire && (rpt_cnt_ff < CNT_W'(stt_pkg::MAX_RESULTS));
   // a second report needs the buffered one moved out first
   assign go      = !(is_tick && report && pend_vld_ff && !rsp_free);

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      idx_in      = idx_ff;
      more_in     = more_ff;
      ev_vld_in   = ev_vld_ff;
      ev_idx_in   = ev_idx_ff;
      valid_in    = valid_ff;
      id_ctr_in   = id_ctr_ff;
      time_in     = time_ff;
      pend_vld_in = pend_vld_ff;
      pend_id_in  = pend_id_ff;
      rpt_cnt_in  = rpt_cnt_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      rsp_in      = rsp_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_waddr   = ev_idx_ff;
      ram_raddr   = idx_ff;
      ram_wdata   = ram_rdata;

      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               item_in    = req_data;
               idx_in     = '0;
               more_in    = 1'b1;
               ev_vld_in  = 1'b0;
               rpt_cnt_in = '0;
               case (req_data.opcode)
                  stt_pkg::OP_CREATE: begin
                     state_in = ST_CREATE;
                  end
                  stt_pkg::OP_DESTROY: begin
                     state_in = ST_WALK;
                  end
                  stt_pkg::OP_TICK: begin
                     if (time_ff != '1) begin
                        time_in = time_ff + 1'b1;
                     end
                     state_in = ST_WALK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_CREATE: begin
            if (rsp_free) begin
               if (!valid_ff[idx_ff]) begin
                  ram_we               = 1'b1;
                  ram_waddr            = idx_ff;
                  ram_wdata.id         = id_ctr_ff + 1'b1;
                  ram_wdata.span       = item_ff.span_ticks;
                  ram_wdata.last_fired = time_ff;
                  ram_wdata.one_shot   = item_ff.one_shot;
                  valid_in[idx_ff]     = 1'b1;
                  id_ctr_in            = id_ctr_ff + 1'b1;
                  rsp_vld_in           = 1'b1;
                  rsp_in.kind          = stt_pkg::KIND_CREATED;
                  rsp_in.timer_id      = id_ctr_ff + 1'b1;
                  rsp_in.last_of_run   = 1'b1;
                  state_in             = ST_IDLE;
               end else if (idx_ff == LAST_IDX) begin
                  rsp_vld_in         = 1'b1;
                  rsp_in.kind        = stt_pkg::KIND_FULL;
                  rsp_in.timer_id    = '0;
                  rsp_in.last_of_run = 1'b1;
                  state_in           = ST_IDLE;
               end else begin
                  idx_in = IDX_W'(idx_ff + 1'b1);
               end
            end
         end

         ST_WALK: begin
            if (!more_ff && !ev_vld_ff) begin
               state_in = is_tick ? ST_FLUSH : ST_IDLE;
            end else if (go) begin
               if (more_ff) begin
                  ram_re    = 1'b1;
                  ev_vld_in = 1'b1;
                  ev_idx_in = idx_ff;
                  if (idx_ff == LAST_IDX) begin
                     more_in = 1'b0;
                  end else begin
                     idx_in = IDX_W'(idx_ff + 1'b1);
                  end
               end else begin
                  ev_vld_in = 1'b0;
               end

               if (!is_tick) begin
                  if (hit) begin
                     valid_in[ev_idx_ff] = 1'b0;
                     ev_vld_in           = 1'b0;
                     state_in            = ST_IDLE;
                  end
               end else if (fire) begin
                  if (ram_rdata.one_shot) begin
                     valid_in[ev_idx_ff] = 1'b0;
                  end else begin
                     ram_we               = 1'b1;
                     ram_waddr            = ev_idx_ff;
                     ram_wdata.last_fired = time_ff;
                  end
                  if (report) begin
                     rpt_cnt_in  = rpt_cnt_ff + 1'b1;
                     pend_vld_in = 1'b1;
                     pend_id_in  = ram_rdata.id;
                     if (pend_vld_ff) begin
                        rsp_vld_in         = 1'b1;
                        rsp_in.kind        = stt_pkg::KIND_FIRED;
                        rsp_in.timer_id    = pend_id_ff;
                        rsp_in.last_of_run = 1'b0;
                     end
                  end
               end
            end
         end

         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_vld_in         = 1'b1;
               rsp_in.kind        = stt_pkg::KIND_FIRED;
               rsp_in.timer_id    = pend_id_ff;
               rsp_in.last_of_run = 1'b1;
               pend_vld_in        = 1'b0;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         more_ff     <= 1'b0;
         ev_vld_ff   <= 1'b0;
         valid_ff    <= '0;
         id_ctr_ff   <= '0;
         time_ff     <= '0;
         pend_vld_ff <= 1'b0;
         rpt_cnt_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         more_ff     <= more_in;
         ev_vld_ff   <= ev_vld_in;
         valid_ff    <= valid_in;
         id_ctr_ff   <= id_ctr_in;
         time_ff     <= time_in;
         pend_vld_ff <= pend_vld_in;
         rpt_cnt_ff  <= rpt_cnt_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      item_ff    <= item_in;
      idx_ff     <= idx_in;
      ev_idx_ff  <= ev_idx_in;
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
   end

   a_rpt_cap: assert property (@(posedge clock) disable iff (reset)
      rpt_cnt_ff <= CNT_W'(stt_pkg::MAX_RESULTS))
      else $error("fired word count past limit");

   a_time_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> time_ff >= $past(time_ff))
      else $error("time counter went backward");

   a_pend_scope: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (state_ff == ST_WALK || state_ff == ST_FLUSH))
      else $error("buffered fired word left outside a tick");

   a_ram_same_addr: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("slot read and write collide on one entry");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != stt_pkg::KIND_FIRED) |-> rsp_data.last_of_run)
      else $error("create word not marked last");

endmodule
